// File: hdl/assert_macros.svh
// Assertion macros used by the call state table controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("call state table: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("call state table: next-cycle check failed");

`endif

// File: hdl/tlcs_pkg.sv
// Package: types, codes and sizes for the telephone line call state table.
`timescale 1ns / 1ps
`default_nettype none

package tlcs_pkg;

  localparam int NUM_LINES = 16;
  localparam int LINE_W    = 4;
  localparam int IDX_W     = $clog2(NUM_LINES);
  localparam int ACT_W     = 3;
  localparam int ST_W      = 3;

  localparam logic [ACT_W-1:0] ACT_REGISTER = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PICKUP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_HANGUP   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIAL     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CHAT     = 3'd4;

  localparam logic [ST_W-1:0] ST_ON_HOOK   = 3'd0;
  localparam logic [ST_W-1:0] ST_RINGING   = 3'd1;
  localparam logic [ST_W-1:0] ST_DIAL_TONE = 3'd2;
  localparam logic [ST_W-1:0] ST_RING_BACK = 3'd3;
  localparam logic [ST_W-1:0] ST_BUSY      = 3'd4;
  localparam logic [ST_W-1:0] ST_CONNECTED = 3'd5;
  localparam logic [ST_W-1:0] ST_ERROR     = 3'd6;

  typedef struct packed {
    logic [ST_W-1:0]   st;
    logic [LINE_W-1:0] peer;
  } entry_t;

  typedef struct packed {
    logic [LINE_W-1:0] dest;
    logic              kind;
    logic [ST_W-1:0]   st;
    logic              shows;
    logic [LINE_W-1:0] num;
    logic              status;
    logic              last;
  } result_t;

  typedef struct packed {
    logic load;
    logic rd_a;
    logic rd_b;
    logic eval;
    logic wr_b;
    logic sel_second;
  } tlcs_cmd_t;

  typedef struct packed {
    logic [1:0] num_res;
  } tlcs_sts_t;

endpackage

`default_nettype wire

// File: hdl/telephone_line_call_state_table.sv
// Top level: telephone line call state table, controller plus datapath.
// Usage:
//   Input channel (in_valid/in_stall) carries one action for one line: register,
//   pickup, hangup, dial (with target_line/target_known) or chat. A transfer takes
//   place on a rising edge with in_valid high and in_stall low.
//   Result channel (out_valid/out_stall) delivers zero, one or two notifications
//   per action; out_last marks the final one. Ignored actions give no result.
//   One item is in work at a time. After the input transfer the block reads
//   the acting line's entry and then the peer or target entry from the table
//   memory, evaluates and writes the acting line, and then writes the second
//   line through the single write port. The first result is offered once the
//   second-line write step is done, a second one in the cycle after the first
//   is taken; the next input transfer waits until the last result is taken, or
//   until the second-line write step is done when nothing is reported.
//   A stalled result holds steady until taken; in_stall stays high meanwhile.
//   Reset (rst_n low, synchronous) marks all lines unregistered with no peer;
//   a line's call state reads as on hook until it is registered.
`timescale 1ns / 1ps
`default_nettype none

module telephone_line_call_state_table import tlcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [LINE_W-1:0] in_line,
  input  wire logic [LINE_W-1:0] in_target_line,
  input  wire logic              in_target_known,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [LINE_W-1:0]      out_dest_line,
  output logic                   out_kind,
  output logic [ST_W-1:0]        out_line_state,
  output logic                   out_shows_number,
  output logic [LINE_W-1:0]      out_shown_number,
  output logic                   out_status,
  output logic                   out_last
);

  tlcs_cmd_t cmd;
  tlcs_sts_t sts;

  tlcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlcs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_line          (in_line),
    .in_target_line   (in_target_line),
    .in_target_known  (in_target_known),
    .cmd              (cmd),
    .sts              (sts),
    .out_dest_line    (out_dest_line),
    .out_kind         (out_kind),
    .out_line_state   (out_line_state),
    .out_shows_number (out_shows_number),
    .out_shown_number (out_shown_number),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// File: hdl/tlcs_datapath.sv
// Datapath: line table memory, registered/peer flags, rule evaluation and result registers.
`timescale 1ns / 1ps
`default_nettype none

module tlcs_datapath import tlcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [LINE_W-1:0] in_line,
  input  wire logic [LINE_W-1:0] in_target_line,
  input  wire logic              in_target_known,
  input  wire tlcs_cmd_t         cmd,
  output tlcs_sts_t              sts,
  output logic [LINE_W-1:0]      out_dest_line,
  output logic                   out_kind,
  output logic [ST_W-1:0]        out_line_state,
  output logic                   out_shows_number,
  output logic [LINE_W-1:0]      out_shown_number,
  output logic                   out_status,
  output logic                   out_last
);

  function automatic logic in_rng(logic [LINE_W-1:0] x);
    return int'(x) < NUM_LINES;
  endfunction

  function automatic result_t notify(logic [LINE_W-1:0] ln, entry_t e);
    result_t r;
    r.dest   = ln;
    r.kind   = 1'b0;
    r.st     = e.st;
    r.shows  = (e.st == ST_ON_HOOK) || (e.st == ST_CONNECTED);
    r.num    = (e.st == ST_ON_HOOK) ? ln : ((e.st == ST_CONNECTED) ? e.peer : '0);
    r.status = (e.st == ST_ERROR);
    r.last   = 1'b0;
    return r;
  endfunction

  // latched item
  logic [ACT_W-1:0]  act_r;
  logic [LINE_W-1:0] ln_r;
  logic [LINE_W-1:0] tgt_r;
  logic              known_r;

  // line table: call state and peer link, reset covered by the registered bits
  entry_t            mem [NUM_LINES];
  entry_t            rd_a_r;
  entry_t            rd_b_r;
  logic [LINE_W-1:0] b_r;
  logic [LINE_W-1:0] b_sel;

  logic [NUM_LINES-1:0] reg_v_r, reg_v_nxt;
  logic [NUM_LINES-1:0] hp_v_r, hp_v_nxt;

  logic [1:0] num_res_r, num_res_nxt;
  logic       wr_b_r, wr_b_nxt;
  entry_t     ent_b_r;
  result_t    res0_r, res0_nxt;
  result_t    res1_r, res1_nxt;

  logic              mem_we;
  logic [LINE_W-1:0] mem_wa;
  entry_t            mem_wd;

  // evaluation
  entry_t             ea, eb, na, nb;
  logic               wr_a, pv, force_fail, chat;
  logic [IDX_W-1:0]   ax, bx, tx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      ln_r    <= in_line;
      tgt_r   <= in_target_line;
      known_r <= in_target_known;
    end
  end

  // dial looks at the target, everything else at the peer of the acting line
  assign b_sel = (act_r == ACT_DIAL) ? tgt_r : rd_a_r.peer;

  assign mem_we = (cmd.eval && wr_a) || (cmd.wr_b && wr_b_r);
  assign mem_wa = cmd.wr_b ? b_r : ln_r;
  assign mem_wd = cmd.wr_b ? ent_b_r : na;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa[IDX_W-1:0]] <= mem_wd;
    if (cmd.rd_a) rd_a_r <= mem[ln_r[IDX_W-1:0]];
    if (cmd.rd_b) begin
      rd_b_r <= mem[b_sel[IDX_W-1:0]];
      b_r    <= b_sel;
    end
  end

  assign ax = ln_r[IDX_W-1:0];
  assign bx = b_r[IDX_W-1:0];
  assign tx = tgt_r[IDX_W-1:0];

  always_comb begin
    ea.st   = reg_v_r[ax] ? rd_a_r.st : ST_ON_HOOK;
    ea.peer = rd_a_r.peer;
    eb.st   = reg_v_r[bx] ? rd_b_r.st : ST_ON_HOOK;
    eb.peer = rd_b_r.peer;
    na = ea;
    nb = eb;
    wr_a = 1'b0;
    wr_b_nxt = 1'b0;
    reg_v_nxt = reg_v_r;
    hp_v_nxt = hp_v_r;
    num_res_nxt = 2'd0;
    force_fail = 1'b0;
    chat = 1'b0;
    pv = hp_v_r[ax] && in_rng(ea.peer);

    if ((act_r <= ACT_CHAT) && in_rng(ln_r)) begin
      if (act_r == ACT_REGISTER) begin
        num_res_nxt = 2'd1;
        if (!reg_v_r[ax]) begin
          reg_v_nxt[ax] = 1'b1;
          hp_v_nxt[ax]  = 1'b0;
          na.st = ST_ON_HOOK;
          wr_a = 1'b1;
        end
      end else if (reg_v_r[ax]) begin
        num_res_nxt = 2'd1;
        case (act_r)
          ACT_PICKUP: begin
            if (ea.st == ST_ON_HOOK) begin
              na.st = ST_DIAL_TONE;
              wr_a = 1'b1;
            end else if (ea.st == ST_RINGING && pv) begin
              na.st = ST_CONNECTED;
              nb.st = ST_CONNECTED;
              wr_a = 1'b1;
              wr_b_nxt = 1'b1;
              num_res_nxt = 2'd2;
            end
          end
          ACT_HANGUP: begin
            if (ea.st inside {ST_CONNECTED, ST_RINGING, ST_RING_BACK}) begin
              na.st = ST_ON_HOOK;
              wr_a = 1'b1;
              hp_v_nxt[ax] = 1'b0;
              if (pv) begin
                nb.st = (ea.st == ST_RING_BACK) ? ST_ON_HOOK : ST_DIAL_TONE;
                hp_v_nxt[bx] = 1'b0;
                wr_b_nxt = 1'b1;
                num_res_nxt = 2'd2;
              end
            end else if (ea.st inside {ST_DIAL_TONE, ST_BUSY, ST_ERROR}) begin
              na.st = ST_ON_HOOK;
              wr_a = 1'b1;
            end
          end
          ACT_DIAL: begin
            if (ea.st == ST_DIAL_TONE) begin
              wr_a = 1'b1;
              if (!known_r || !in_rng(tgt_r) || !reg_v_r[tx]) begin
                na.st = ST_ERROR;
              end else if (tgt_r == ln_r || hp_v_r[tx] || eb.st != ST_ON_HOOK) begin
                na.st = ST_BUSY;
              end else begin
                na.st   = ST_RING_BACK;
                na.peer = tgt_r;
                nb.st   = ST_RINGING;
                nb.peer = ln_r;
                hp_v_nxt[ax] = 1'b1;
                hp_v_nxt[tx] = 1'b1;
                wr_b_nxt = 1'b1;
                num_res_nxt = 2'd2;
              end
            end
          end
          default: begin
            if (ea.st == ST_CONNECTED && pv) begin
              chat = 1'b1;
              num_res_nxt = 2'd2;
            end else begin
              force_fail = 1'b1;
            end
          end
        endcase
      end
    end

    res0_nxt = notify(ln_r, na);
    res0_nxt.status = res0_nxt.status | force_fail;
    res0_nxt.last = (num_res_nxt == 2'd1);

    if (chat) begin
      res1_nxt.dest   = b_r;
      res1_nxt.kind   = 1'b1;
      res1_nxt.st     = eb.st;
      res1_nxt.shows  = 1'b0;
      res1_nxt.num    = '0;
      res1_nxt.status = 1'b0;
    end else begin
      res1_nxt = notify(b_r, nb);
    end
    res1_nxt.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_v_r   <= '0;
      hp_v_r    <= '0;
      num_res_r <= 2'd0;
      wr_b_r    <= 1'b0;
    end else if (cmd.eval) begin
      reg_v_r   <= reg_v_nxt;
      hp_v_r    <= hp_v_nxt;
      num_res_r <= num_res_nxt;
      wr_b_r    <= wr_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ent_b_r <= nb;
      res0_r  <= res0_nxt;
      res1_r  <= res1_nxt;
    end
  end

  assign sts.num_res = num_res_r;

  result_t res_out;
  assign res_out = cmd.sel_second ? res1_r : res0_r;

  assign out_dest_line    = res_out.dest;
  assign out_kind         = res_out.kind;
  assign out_line_state   = res_out.st;
  assign out_shows_number = res_out.shows;
  assign out_shown_number = res_out.num;
  assign out_status       = res_out.status;
  assign out_last         = res_out.last;

endmodule

`default_nettype wire

// File: hdl/tlcs_ctrl.sv
// Controller: sequences table reads, evaluation, peer write and result transfers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlcs_ctrl import tlcs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire tlcs_sts_t sts,
  output tlcs_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_WRB  = 3'd4;
  localparam logic [2:0] S_OUT1 = 3'd5;
  localparam logic [2:0] S_OUT2 = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_WRB;
      S_WRB:  state_nxt = (sts.num_res == 2'd0) ? S_IDLE : S_OUT1;
      S_OUT1: begin
        if (!out_stall) state_nxt = (sts.num_res == 2'd2) ? S_OUT2 : S_IDLE;
      end
      S_OUT2: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT1) || (state_r == S_OUT2);

  assign cmd.load       = in_valid && (state_r == S_IDLE);
  assign cmd.rd_a       = (state_r == S_RDA);
  assign cmd.rd_b       = (state_r == S_RDB);
  assign cmd.eval       = (state_r == S_EVAL);
  assign cmd.wr_b       = (state_r == S_WRB);
  assign cmd.sel_second = (state_r == S_OUT2);

  `TLCS_ASSERT_IMP(a_out_holds_in, clk, rst_n, out_valid, in_stall)
  `TLCS_ASSERT_IMP(a_second_needs_two, clk, rst_n, state_r == S_OUT2, sts.num_res == 2'd2)
  `TLCS_ASSERT_IMP(a_out_has_result, clk, rst_n, out_valid, sts.num_res != 2'd0)
  `TLCS_ASSERT_NXT(a_accept_reads, clk, rst_n, in_valid && !in_stall, state_r == S_RDA)

endmodule

`default_nettype wire

// File: test/tb_telephone_line_call_state_table.sv
// Testbench for the telephone line call state table: directed and random call traffic against a scoreboard.
`timescale 1ns / 1ps

module tb_telephone_line_call_state_table;
  import tlcs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam logic             KIND_STATE    = 1'b0;
  localparam logic             KIND_CHAT     = 1'b1;
  localparam logic             STATUS_FAIL   = 1'b1;
  localparam int FIRST_LINE   = 0;
  localparam int LAST_LINE    = NUM_LINES - 1;
  // never registered on purpose, so dial can hit an unregistered target
  localparam int SPARE_A      = 13;
  localparam int SPARE_B      = 14;
  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] target;
    logic              known;
  } call_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  in_action = '0;
  logic [LINE_W-1:0] in_line = '0;
  logic [LINE_W-1:0] in_target_line = '0;
  logic              in_target_known = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [LINE_W-1:0] out_dest_line;
  logic              out_kind;
  logic [ST_W-1:0]   out_line_state;
  logic              out_shows_number;
  logic [LINE_W-1:0] out_shown_number;
  logic              out_status;
  logic              out_last;

  call_req_t call_queue[$];
  result_t   pending_notices[$];
  int unsigned total_items = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // shadow copy of the line table
  logic              line_reg[NUM_LINES];
  logic [ST_W-1:0]   line_st[NUM_LINES];
  logic              line_linked[NUM_LINES];
  logic [LINE_W-1:0] line_peer[NUM_LINES];

  telephone_line_call_state_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_line          (in_line),
    .in_target_line   (in_target_line),
    .in_target_known  (in_target_known),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dest_line    (out_dest_line),
    .out_kind         (out_kind),
    .out_line_state   (out_line_state),
    .out_shows_number (out_shows_number),
    .out_shown_number (out_shown_number),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < NUM_LINES; i++) begin
      line_reg[i] = 1'b0;
      line_st[i] = ST_ON_HOOK;
      line_linked[i] = 1'b0;
      line_peer[i] = '0;
    end
  end

  function automatic int unsigned send_idle_pct();
    if (items_taken < total_items / 3) return 27;
    if (items_taken < 2 * total_items / 3) return 51;
    return 0;
  endfunction

  function automatic int unsigned recv_stall_pct();
    if (items_taken < total_items / 3) return 51;
    if (items_taken < 2 * total_items / 3) return 27;
    return 0;
  endfunction

  function automatic result_t line_notice(input logic [LINE_W-1:0] ln);
    result_t r;
    r = '0;
    r.dest = ln;
    r.kind = KIND_STATE;
    r.st = line_st[ln];
    if (r.st == ST_ON_HOOK) begin
      r.shows = 1'b1;
      r.num = ln;
    end else if (r.st == ST_CONNECTED) begin
      r.shows = 1'b1;
      r.num = line_peer[ln];
    end
    r.status = (r.st == ST_ERROR);
    return r;
  endfunction

  // Apply one action to the shadow table and queue the notifications it causes.
  function automatic void apply_call(input call_req_t req);
    result_t notes[$];
    result_t chat;
    logic [LINE_W-1:0] ln, pr, tgt;
    logic [ST_W-1:0] st;
    logic pv;
    logic second;
    ln = req.line;
    tgt = req.target;
    second = 1'b0;
    if (req.action > ACT_CHAT) return;
    if (req.action == ACT_REGISTER) begin
      if (!line_reg[ln]) begin
        line_reg[ln] = 1'b1;
        line_st[ln] = ST_ON_HOOK;
        line_linked[ln] = 1'b0;
      end
      notes.push_back(line_notice(ln));
    end else begin
      if (!line_reg[ln]) return;
      st = line_st[ln];
      pr = line_peer[ln];
      pv = line_linked[ln];
      case (req.action)
        ACT_PICKUP: begin
          if (st == ST_ON_HOOK) begin
            line_st[ln] = ST_DIAL_TONE;
          end else if (st == ST_RINGING && pv) begin
            line_st[ln] = ST_CONNECTED;
            line_st[pr] = ST_CONNECTED;
            second = 1'b1;
          end
          notes.push_back(line_notice(ln));
          if (second) notes.push_back(line_notice(pr));
        end
        ACT_HANGUP: begin
          if (st == ST_CONNECTED || st == ST_RINGING || st == ST_RING_BACK) begin
            line_st[ln] = ST_ON_HOOK;
            if (pv) begin
              line_st[pr] = (st == ST_RING_BACK) ? ST_ON_HOOK : ST_DIAL_TONE;
              line_linked[pr] = 1'b0;
              second = 1'b1;
            end
            line_linked[ln] = 1'b0;
          end else if (st == ST_DIAL_TONE || st == ST_BUSY || st == ST_ERROR) begin
            line_st[ln] = ST_ON_HOOK;
          end
          notes.push_back(line_notice(ln));
          if (second) notes.push_back(line_notice(pr));
        end
        ACT_DIAL: begin
          if (st == ST_DIAL_TONE) begin
            if (!req.known || !line_reg[tgt]) begin
              line_st[ln] = ST_ERROR;
            end else if (tgt == ln || line_linked[tgt] || line_st[tgt] != ST_ON_HOOK) begin
              line_st[ln] = ST_BUSY;
            end else begin
              line_st[ln] = ST_RING_BACK;
              line_st[tgt] = ST_RINGING;
              line_linked[ln] = 1'b1;
              line_peer[ln] = tgt;
              line_linked[tgt] = 1'b1;
              line_peer[tgt] = ln;
              second = 1'b1;
            end
          end
          notes.push_back(line_notice(ln));
          if (second) notes.push_back(line_notice(tgt));
        end
        default: begin
          if (st == ST_CONNECTED && pv) begin
            notes.push_back(line_notice(ln));
            chat = '0;
            chat.dest = pr;
            chat.kind = KIND_CHAT;
            chat.st = line_st[pr];
            notes.push_back(chat);
          end else begin
            chat = line_notice(ln);
            chat.status = STATUS_FAIL;
            notes.push_back(chat);
          end
        end
      endcase
    end
    notes[notes.size() - 1].last = 1'b1;
    foreach (notes[i]) pending_notices.push_back(notes[i]);
  endfunction

  function automatic void check_notice();
    result_t got, want;
    got.dest = out_dest_line;
    got.kind = out_kind;
    got.st = out_line_state;
    got.shows = out_shows_number;
    got.num = out_shown_number;
    got.status = out_status;
    got.last = out_last;
    if (pending_notices.size() == 0) begin
      if (mismatches < REPORT_MAX)
        $display("unexpected notice dest=%0d kind=%0d st=%0d shows=%0d num=%0d status=%0d last=%0d",
                 got.dest, got.kind, got.st, got.shows, got.num, got.status, got.last);
      mismatches++;
    end else begin
      want = pending_notices.pop_front();
      if (got !== want) begin
        if (mismatches < REPORT_MAX) begin
          $display("notice mismatch at %0t", $realtime);
          $display("  exp dest=%0d kind=%0d st=%0d shows=%0d num=%0d status=%0d last=%0d",
                   want.dest, want.kind, want.st, want.shows, want.num, want.status,
                   want.last);
          $display("  got dest=%0d kind=%0d st=%0d shows=%0d num=%0d status=%0d last=%0d",
                   got.dest, got.kind, got.st, got.shows, got.num, got.status, got.last);
        end
        mismatches++;
      end
    end
  endfunction

  function automatic void queue_action(input logic [ACT_W-1:0] act, input int ln);
    call_req_t req;
    req.action = act;
    req.line = LINE_W'(ln);
    req.target = LINE_W'($urandom_range(LAST_LINE));
    req.known = 1'($urandom_range(1));
    call_queue.push_back(req);
  endfunction

  function automatic void queue_dial(input int ln, input int tgt, input bit known);
    call_req_t req;
    req.action = ACT_DIAL;
    req.line = LINE_W'(ln);
    req.target = LINE_W'(tgt);
    req.known = known;
    call_queue.push_back(req);
  endfunction

  function automatic int pool_line();
    int l;
    do l = $urandom_range(LAST_LINE); while (l == SPARE_A || l == SPARE_B);
    return l;
  endfunction

  // input side: hold while stalled, otherwise offer the next pending action or idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_call(call_queue.pop_front());
        items_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (call_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          in_valid <= 1'b1;
          in_action <= call_queue[0].action;
          in_line <= call_queue[0].line;
          in_target_line <= call_queue[0].target;
          in_target_known <= call_queue[0].known;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_notice();
      out_stall <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int a, b, c, pick, branch, directed_n;

    // unregistered actor and unused codes: all ignored
    queue_action(ACT_CHAT, FIRST_LINE);
    queue_action(ACT_UNUSED_LO, LAST_LINE);
    queue_action(ACT_UNUSED_HI, FIRST_LINE);
    queue_action(ACT_REGISTER, FIRST_LINE);
    queue_action(ACT_REGISTER, LAST_LINE);
    queue_action(ACT_REGISTER, FIRST_LINE);
    queue_action(ACT_HANGUP, FIRST_LINE);
    queue_action(ACT_PICKUP, FIRST_LINE);
    queue_action(ACT_PICKUP, FIRST_LINE);
    queue_dial(FIRST_LINE, LAST_LINE, 1'b0);
    queue_action(ACT_HANGUP, FIRST_LINE);
    queue_action(ACT_PICKUP, FIRST_LINE);
    queue_dial(FIRST_LINE, 3, 1'b1);
    queue_action(ACT_HANGUP, FIRST_LINE);
    queue_action(ACT_PICKUP, FIRST_LINE);
    queue_dial(FIRST_LINE, FIRST_LINE, 1'b1);
    queue_action(ACT_HANGUP, FIRST_LINE);
    queue_action(ACT_PICKUP, LAST_LINE);
    queue_action(ACT_PICKUP, FIRST_LINE);
    queue_dial(FIRST_LINE, LAST_LINE, 1'b1);
    queue_action(ACT_HANGUP, FIRST_LINE);
    queue_action(ACT_HANGUP, LAST_LINE);
    queue_action(ACT_PICKUP, FIRST_LINE);
    queue_dial(FIRST_LINE, LAST_LINE, 1'b1);
    queue_action(ACT_CHAT, FIRST_LINE);
    queue_action(ACT_PICKUP, LAST_LINE);
    queue_action(ACT_CHAT, LAST_LINE);
    queue_action(ACT_CHAT, FIRST_LINE);
    queue_action(ACT_HANGUP, FIRST_LINE);
    queue_action(ACT_HANGUP, LAST_LINE);
    directed_n = call_queue.size();

    for (int l = 0; l < NUM_LINES; l++)
      if (l != SPARE_A && l != SPARE_B) queue_action(ACT_REGISTER, l);

    while (call_queue.size() < directed_n + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      a = pool_line();
      do b = pool_line(); while (b == a);
      if (pick < 8) begin
        // noise: any code except register, so the spare lines stay unregistered
        queue_dial(0, $urandom_range(LAST_LINE), 1'($urandom_range(1)));
        call_queue[call_queue.size() - 1].action = ACT_W'($urandom_range(ACT_PICKUP,
                                                                         ACT_UNUSED_HI));
        call_queue[call_queue.size() - 1].line = LINE_W'($urandom_range(LAST_LINE));
      end else if (pick < 14) begin
        queue_action(ACT_REGISTER, a);
      end else begin
        queue_action(ACT_PICKUP, a);
        pick = $urandom_range(99);
        if (pick < 8) queue_dial(a, b, 1'b0);
        else if (pick < 14) queue_dial(a, $urandom_range(SPARE_A, SPARE_B), 1'b1);
        else if (pick < 18) queue_dial(a, a, 1'b1);
        else queue_dial(a, b, 1'b1);
        branch = $urandom_range(99);
        if (branch < 50) begin
          queue_action(ACT_PICKUP, b);
          repeat ($urandom_range(3)) queue_action(ACT_CHAT, $urandom_range(1) ? a : b);
          if ($urandom_range(1)) begin
            queue_action(ACT_HANGUP, a);
            queue_action(ACT_HANGUP, b);
          end else begin
            queue_action(ACT_HANGUP, b);
            queue_action(ACT_HANGUP, a);
          end
        end else if (branch < 70) begin
          queue_action(ACT_HANGUP, a);
        end else if (branch < 88) begin
          queue_action(ACT_HANGUP, b);
          queue_action(ACT_HANGUP, a);
        end else begin
          // third party dials a line that is already in a call
          do c = pool_line(); while (c == a || c == b);
          queue_action(ACT_PICKUP, c);
          queue_dial(c, $urandom_range(1) ? b : a, 1'b1);
          queue_action(ACT_HANGUP, c);
          queue_action(ACT_HANGUP, a);
        end
      end
    end
    total_items = call_queue.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (call_queue.size() != 0 || in_valid);
    while (pending_notices.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_notices.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: telephone_line_call_state_table.f
+incdir+hdl
hdl/tlcs_pkg.sv
hdl/tlcs_datapath.sv
hdl/tlcs_ctrl.sv
hdl/telephone_line_call_state_table.sv
test/tb_telephone_line_call_state_table.sv
